// ===== rtl/core/spdd_pkg.sv =====
package spdd_pkg;

  localparam int NUM_LEVELS  = 10;
  localparam int LEVEL_DEPTH = 4;
  localparam int HANDLE_BITS = 32;
  localparam int STORE_SIZE  = NUM_LEVELS * LEVEL_DEPTH;

  localparam int LVL_W   = $clog2(NUM_LEVELS);
  localparam int HEAD_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int FILL_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W   = $clog2(2 * LEVEL_DEPTH);
  localparam int ADDR_W  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int TOTAL_W = $clog2(STORE_SIZE + 1);

  localparam int KIND_W      = 4;
  localparam int PRIO_IN_W   = 8;
  localparam int PRIO_OUT_W  = 4;
  localparam int TOTAL_OUT_W = 6;
  localparam int OUT_HANDLE_W = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 2;
  localparam int DEF_PRIO_W  = 4;

  localparam logic [DEF_PRIO_W-1:0] DEFAULT_PRIO_RESET = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_DEFAULT_PRIO = 2'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_TAIL = 4'd0,
    KIND_PUSH_HEAD = 4'd1,
    KIND_POP       = 4'd2,
    KIND_PEEK      = 4'd3,
    KIND_START     = 4'd4,
    KIND_STOP      = 4'd5,
    KIND_CLOSE     = 4'd6,
    KIND_CLEAR     = 4'd7,
    KIND_DRAIN     = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [HANDLE_BITS-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

  typedef struct packed {
    logic                   strobe;
    status_t                status;
    logic                   from_mem;
    logic [PRIO_OUT_W-1:0]  lvl;
    logic [TOTAL_OUT_W-1:0] total;
    logic                   last;
  } result_t;

endpackage

// ===== rtl/core/strict_priority_deque_dispatcher_unit.sv =====
// Strict priority dispatcher over ten small deques of message handles. A word is
// taken when start is high and busy is low. Each word but a drain passes through
// the execute state, in which the level pointers are updated and the entry memory
// is read or written, and its result is strobed on out_strobe in the next cycle,
// when busy is already low again and the next word can be taken. A drain emits
// one result per cycle for every stored entry, highest level first, and keeps
// busy high until its last entry has been read. The receiver cannot stall:
// each result is valid for the single cycle in which out_strobe is high.
module strict_priority_deque_dispatcher_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [spdd_pkg::KIND_W-1:0]         in_kind,
  input  logic [spdd_pkg::HANDLE_BITS-1:0]    in_message_handle,
  input  logic signed [spdd_pkg::PRIO_IN_W-1:0] in_message_priority,
  input  logic                                in_no_priority,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic [spdd_pkg::OUT_HANDLE_W-1:0]   out_out_handle,
  output logic [spdd_pkg::PRIO_OUT_W-1:0]     out_out_priority,
  output logic [spdd_pkg::TOTAL_OUT_W-1:0]    out_queued_total,
  output logic                                out_last_result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [spdd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [spdd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [spdd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import spdd_pkg::*;

  logic [DEF_PRIO_W-1:0]  default_prio_r;
  mem_req_t               mem_req;
  result_t                res;
  logic [HANDLE_BITS-1:0] rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_DEFAULT_PRIO) ? CFG_DATA_W'(default_prio_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_prio_r <= DEFAULT_PRIO_RESET;
    end else if (psel && penable && pwrite && pready) begin
      default_prio_r <= pwdata[DEF_PRIO_W-1:0];
    end
  end

  spdd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (in_kind),
    .handle       (in_message_handle),
    .prio         (in_message_priority),
    .no_prio      (in_no_priority),
    .default_prio (default_prio_r),
    .mem_req      (mem_req),
    .res          (res)
  );

  spdd_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  assign out_strobe       = res.strobe;
  assign out_status       = res.status;
  assign out_out_handle   = res.from_mem ? OUT_HANDLE_W'(rdata) : '0;
  assign out_out_priority = res.lvl;
  assign out_queued_total = res.total;
  assign out_last_result  = res.last;

endmodule

// ===== rtl/core/spdd_store.sv =====
module spdd_store (
  input  logic                             clk,
  input  spdd_pkg::mem_req_t               mem_req,
  output logic [spdd_pkg::HANDLE_BITS-1:0] rdata
);
  import spdd_pkg::*;

  logic [HANDLE_BITS-1:0] mem [STORE_SIZE];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata <= mem[mem_req.raddr];
    end
  end

endmodule

// ===== rtl/core/spdd_ctrl.sv =====
module spdd_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [spdd_pkg::KIND_W-1:0]       kind,
  input  logic [spdd_pkg::HANDLE_BITS-1:0]  handle,
  input  logic [spdd_pkg::PRIO_IN_W-1:0]    prio,
  input  logic                              no_prio,
  input  logic [spdd_pkg::DEF_PRIO_W-1:0]   default_prio,
  output spdd_pkg::mem_req_t                mem_req,
  output spdd_pkg::result_t                 res
);
  import spdd_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  function automatic logic [LVL_W-1:0] pick_level(
    input logic [PRIO_IN_W-1:0]  p,
    input logic                  none,
    input logic [DEF_PRIO_W-1:0] dp
  );
    logic [LVL_W-1:0] l;
    if (none) begin
      if (dp > DEF_PRIO_W'(NUM_LEVELS - 1)) l = LVL_W'(NUM_LEVELS - 1);
      else l = LVL_W'(dp);
    end else if (p[PRIO_IN_W-1]) begin
      l = '0;
    end else if (p > PRIO_IN_W'(NUM_LEVELS - 1)) begin
      l = LVL_W'(NUM_LEVELS - 1);
    end else begin
      l = LVL_W'(p);
    end
    return l;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(
    input logic [LVL_W-1:0]  l,
    input logic [HEAD_W-1:0] h,
    input logic [FILL_W-1:0] off
  );
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(off);
    if (s >= SUM_W'(LEVEL_DEPTH)) s = s - SUM_W'(LEVEL_DEPTH);
    return ADDR_W'(ADDR_W'(l) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(s);
  endfunction

  function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
    return (h == HEAD_W'(LEVEL_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [HEAD_W-1:0] head_dec(input logic [HEAD_W-1:0] h);
    return (h == '0) ? HEAD_W'(LEVEL_DEPTH - 1) : h - 1'b1;
  endfunction

  state_t               state_r, state_nxt;
  logic [HEAD_W-1:0]    head_r [NUM_LEVELS];
  logic [HEAD_W-1:0]    head_nxt [NUM_LEVELS];
  logic [FILL_W-1:0]    fill_r [NUM_LEVELS];
  logic [FILL_W-1:0]    fill_nxt [NUM_LEVELS];
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 running_r, running_nxt;
  logic                 closed_r, closed_nxt;
  result_t              res_r, res_nxt;

  logic [KIND_W-1:0]      kind_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [PRIO_IN_W-1:0]   prio_r;
  logic                   no_prio_r;

  logic [LVL_W-1:0]       pick;
  logic [LVL_W-1:0]       top_lvl;

  assign busy = (state_r != ST_IDLE);
  assign res  = res_r;
  assign pick = pick_level(prio_r, no_prio_r, default_prio);

  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (fill_r[i] != '0) top_lvl = LVL_W'(i);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    running_nxt   = running_r;
    closed_nxt    = closed_r;
    mem_req       = '0;
    mem_req.wdata = handle_r;
    res_nxt       = '0;
    if (state_r == ST_IDLE) begin
      if (start) state_nxt = ST_EXEC;
    end else begin
      state_nxt      = ST_IDLE;
      res_nxt.strobe = 1'b1;
      res_nxt.status = STAT_OK;
      res_nxt.last   = 1'b1;
      case (kind_r)
        KIND_PUSH_TAIL, KIND_PUSH_HEAD: begin
          res_nxt.lvl = PRIO_OUT_W'(pick);
          if (fill_r[pick] >= FILL_W'(LEVEL_DEPTH)) begin
            res_nxt.status = STAT_FULL;
          end else begin
            mem_req.we = 1'b1;
            if (kind_r == KIND_PUSH_TAIL) begin
              mem_req.waddr = slot_addr(pick, head_r[pick], fill_r[pick]);
            end else begin
              head_nxt[pick] = head_dec(head_r[pick]);
              mem_req.waddr  = slot_addr(pick, head_dec(head_r[pick]), '0);
            end
            fill_nxt[pick] = fill_r[pick] + 1'b1;
            total_nxt      = total_r + 1'b1;
          end
        end
        KIND_POP, KIND_PEEK: begin
          if (closed_r || !running_r || total_r == '0) begin
            res_nxt.status = STAT_NONE;
          end else begin
            mem_req.re       = 1'b1;
            mem_req.raddr    = slot_addr(top_lvl, head_r[top_lvl], '0);
            res_nxt.from_mem = 1'b1;
            res_nxt.lvl      = PRIO_OUT_W'(top_lvl);
            if (kind_r == KIND_POP) begin
              head_nxt[top_lvl] = head_inc(head_r[top_lvl]);
              fill_nxt[top_lvl] = fill_r[top_lvl] - 1'b1;
              total_nxt         = total_r - 1'b1;
            end
          end
        end
        KIND_START: begin
          if (!closed_r) running_nxt = 1'b1;
        end
        KIND_STOP: begin
          running_nxt = 1'b0;
        end
        KIND_CLOSE: begin
          running_nxt = 1'b0;
          closed_nxt  = 1'b1;
        end
        KIND_CLEAR: begin
          head_nxt  = '{default: '0};
          fill_nxt  = '{default: '0};
          total_nxt = '0;
        end
        KIND_DRAIN: begin
          if (total_r == '0) begin
            res_nxt.status = STAT_NONE;
          end else begin
            mem_req.re        = 1'b1;
            mem_req.raddr     = slot_addr(top_lvl, head_r[top_lvl], '0);
            res_nxt.from_mem  = 1'b1;
            res_nxt.lvl       = PRIO_OUT_W'(top_lvl);
            head_nxt[top_lvl] = (fill_r[top_lvl] == FILL_W'(1)) ? '0 :
                                head_inc(head_r[top_lvl]);
            fill_nxt[top_lvl] = fill_r[top_lvl] - 1'b1;
            total_nxt         = total_r - 1'b1;
            if (total_r != TOTAL_W'(1)) begin
              res_nxt.last = 1'b0;
              state_nxt    = ST_EXEC;
            end
          end
        end
        default: begin
          res_nxt.status = STAT_NONE;
        end
      endcase
      res_nxt.total = TOTAL_OUT_W'(total_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '{default: '0};
      fill_r    <= '{default: '0};
      total_r   <= '0;
      running_r <= 1'b0;
      closed_r  <= 1'b0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      total_r   <= total_nxt;
      running_r <= running_nxt;
      closed_r  <= closed_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r    <= kind;
      handle_r  <= handle;
      prio_r    <= prio;
      no_prio_r <= no_prio;
    end
  end

endmodule

// ===== rtl/core/spdd_checker.sv =====
module spdd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [31:0] out_out_handle,
  input logic [5:0]  out_queued_total,
  input logic        out_last_result
);
  import spdd_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a preceding execute cycle");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_result |=> out_strobe)
    else $error("drain sequence broke off before its last result");

  a_no_handle_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != STAT_OK |-> out_out_handle == '0)
    else $error("handle delivered with a failing status");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_queued_total <= 6'(STORE_SIZE))
    else $error("queued total exceeds the store size");

endmodule

bind strict_priority_deque_dispatcher_unit spdd_checker u_spdd_checker (.*);

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spdd_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_W'(KIND_DRAIN + 1);
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;

  typedef struct {
    logic [1:0]              status;
    logic [OUT_HANDLE_W-1:0] handle;
    logic [PRIO_OUT_W-1:0]   lvl;
    logic [TOTAL_OUT_W-1:0]  total;
    logic                    last;
  } outcome_t;

  class dispatch_scoreboard;
    logic [HANDLE_BITS-1:0] slot_q [STORE_SIZE];
    logic [HEAD_W-1:0]      head [NUM_LEVELS];
    logic [FILL_W-1:0]      fill [NUM_LEVELS];
    logic [TOTAL_OUT_W-1:0] total;
    bit                     running;
    bit                     closed;
    logic [DEF_PRIO_W-1:0]  def_prio;
    outcome_t               pending [$];
    int errors, words, results, refusals, drained;

    function new();
      foreach (slot_q[i]) slot_q[i] = '0;
      foreach (head[i]) begin
        head[i] = '0;
        fill[i] = '0;
      end
      total = '0;
      running = 1'b0;
      closed = 1'b0;
      def_prio = DEFAULT_PRIO_RESET;
    endfunction

    function void set_default(logic [DEF_PRIO_W-1:0] v);
      def_prio = v;
    endfunction

    function int level_for(logic signed [PRIO_IN_W-1:0] p, logic nop);
      int v;
      if (nop) v = int'(def_prio);
      else v = int'(p);
      if (v < 0) v = 0;
      if (v > NUM_LEVELS - 1) v = NUM_LEVELS - 1;
      return v;
    endfunction

    function int slot(int lvl, int off);
      return lvl * LEVEL_DEPTH + (int'(head[lvl]) + off) % LEVEL_DEPTH;
    endfunction

    function int highest_filled();
      for (int i = NUM_LEVELS - 1; i >= 0; i--)
        if (fill[i] != 0) return i;
      return -1;
    endfunction

    function void post(status_t s, logic [HANDLE_BITS-1:0] h, int lvl, bit last);
      outcome_t o;
      o.status = s;
      o.handle = h;
      o.lvl = PRIO_OUT_W'(lvl);
      o.total = total;
      o.last = last;
      pending.push_back(o);
    endfunction

    function void note_word(logic [KIND_W-1:0] k, logic [HANDLE_BITS-1:0] h,
                            logic signed [PRIO_IN_W-1:0] p, logic nop);
      int lvl;
      int t;
      words++;
      case (k)
        KIND_PUSH_TAIL, KIND_PUSH_HEAD: begin
          lvl = level_for(p, nop);
          if (fill[lvl] >= LEVEL_DEPTH) begin
            refusals++;
            post(STAT_FULL, '0, lvl, 1'b1);
          end else begin
            if (k == KIND_PUSH_TAIL) begin
              slot_q[slot(lvl, int'(fill[lvl]))] = h;
            end else begin
              head[lvl] = HEAD_W'((int'(head[lvl]) + LEVEL_DEPTH - 1) % LEVEL_DEPTH);
              slot_q[slot(lvl, 0)] = h;
            end
            fill[lvl]++;
            total++;
            post(STAT_OK, '0, lvl, 1'b1);
          end
        end
        KIND_POP, KIND_PEEK: begin
          t = highest_filled();
          if (closed || !running || t < 0) begin
            post(STAT_NONE, '0, 0, 1'b1);
          end else begin
            h = slot_q[slot(t, 0)];
            if (k == KIND_POP) begin
              head[t] = HEAD_W'((int'(head[t]) + 1) % LEVEL_DEPTH);
              fill[t]--;
              total--;
            end
            post(STAT_OK, h, t, 1'b1);
          end
        end
        KIND_START: begin
          if (!closed) running = 1'b1;
          post(STAT_OK, '0, 0, 1'b1);
        end
        KIND_STOP: begin
          running = 1'b0;
          post(STAT_OK, '0, 0, 1'b1);
        end
        KIND_CLOSE: begin
          running = 1'b0;
          closed = 1'b1;
          post(STAT_OK, '0, 0, 1'b1);
        end
        KIND_CLEAR: begin
          foreach (head[i]) begin
            head[i] = '0;
            fill[i] = '0;
          end
          total = '0;
          post(STAT_OK, '0, 0, 1'b1);
        end
        KIND_DRAIN: begin
          if (total == 0) begin
            post(STAT_NONE, '0, 0, 1'b1);
          end else begin
            for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
              for (int j = 0; j < int'(fill[i]); j++) begin
                total--;
                drained++;
                post(STAT_OK, slot_q[slot(i, j)], i, total == 0);
              end
              fill[i] = '0;
              head[i] = '0;
            end
          end
        end
        default: post(STAT_NONE, '0, 0, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] s, logic [OUT_HANDLE_W-1:0] h,
                               logic [PRIO_OUT_W-1:0] lvl, logic [TOTAL_OUT_W-1:0] tot,
                               logic last);
      outcome_t o;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected nothing, got status %0h handle %0h",
                 $time, s, h);
        return;
      end
      o = pending.pop_front();
      results++;
      compare_field("status", 32'(o.status), 32'(s));
      compare_field("handle", 32'(o.handle), 32'(h));
      compare_field("priority", 32'(o.lvl), 32'(lvl));
      compare_field("queued total", 32'(o.total), 32'(tot));
      compare_field("last", 32'(o.last), 32'(last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [HANDLE_BITS-1:0] in_message_handle = '0;
  logic signed [PRIO_IN_W-1:0] in_message_priority = '0;
  logic in_no_priority = 1'b0;
  logic out_strobe;
  logic [1:0] out_status;
  logic [OUT_HANDLE_W-1:0] out_out_handle;
  logic [PRIO_OUT_W-1:0] out_out_priority;
  logic [TOTAL_OUT_W-1:0] out_queued_total;
  logic out_last_result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  dispatch_scoreboard sb;
  int idle_pct = 0;

  strict_priority_deque_dispatcher_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_message_handle   (in_message_handle),
    .in_message_priority (in_message_priority),
    .in_no_priority      (in_no_priority),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_out_handle      (out_out_handle),
    .out_out_priority    (out_out_priority),
    .out_queued_total    (out_queued_total),
    .out_last_result     (out_last_result),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      sb.check_result(out_status, out_out_handle, out_out_priority, out_queued_total,
                      out_last_result);
  end

  task automatic send_word(input logic [KIND_W-1:0] k, input logic [HANDLE_BITS-1:0] h,
                           input logic signed [PRIO_IN_W-1:0] p, input logic nop);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_kind = k;
    in_message_handle = h;
    in_message_priority = p;
    in_no_priority = nop;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(k, h, p, nop);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic random_word();
    int r;
    int q;
    logic [KIND_W-1:0] k;
    logic signed [PRIO_IN_W-1:0] p;
    r = $urandom_range(99);
    if (r < 28) k = KIND_PUSH_TAIL;
    else if (r < 46) k = KIND_PUSH_HEAD;
    else if (r < 66) k = KIND_POP;
    else if (r < 74) k = KIND_PEEK;
    else if (r < 80) k = KIND_START;
    else if (r < 83) k = KIND_STOP;
    else if (r < 85) k = KIND_CLEAR;
    else if (r < 89) k = KIND_DRAIN;
    else if (r < 92) k = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
    else k = KIND_PUSH_TAIL;
    q = $urandom_range(99);
    if (q < 60) p = PRIO_IN_W'($urandom_range(NUM_LEVELS - 1, 0));
    else if (q < 70) p = $urandom_range(1) ? 8'sh7f : 8'sh80;
    else p = PRIO_IN_W'($urandom());
    send_word(k, $urandom(), p, q >= 80);
  endtask

  task automatic settle();
    int n;
    n = 0;
    while ((sb.pending.size() != 0 || busy) && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_default(input logic [DEF_PRIO_W-1:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CFG_ADDR_DEFAULT_PRIO;
    pwdata = CFG_DATA_W'(v);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DATA_W'(v)) begin
      sb.errors++;
      $display("%0t: default_priority readback expected %0h, got %0h", $time, v, prdata);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    sb.set_default(v);
  endtask

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_word(KIND_POP, 32'h1, 8'sd0, 1'b0);
    send_word(KIND_DRAIN, 32'h2, 8'sd0, 1'b0);
    send_word(KIND_PUSH_TAIL, 32'h0000_0000, 8'sh80, 1'b0);
    send_word(KIND_PUSH_TAIL, 32'hffff_ffff, 8'sh7f, 1'b0);
    send_word(KIND_PUSH_HEAD, 32'ha5a5_5a5a, 8'sh7f, 1'b1);
    send_word(KIND_PEEK, 32'h3, 8'sd0, 1'b0);
    send_word(KIND_START, 32'h4, 8'sd0, 1'b0);
    send_word(KIND_PEEK, 32'h5, 8'sd0, 1'b0);
    send_word(KIND_POP, 32'h6, 8'sd0, 1'b0);
    send_word(KIND_POP, 32'h7, 8'sd0, 1'b0);
    send_word(KIND_PUSH_TAIL, 32'h3000_0001, 8'sd3, 1'b0);
    send_word(KIND_PUSH_HEAD, 32'h3000_0002, 8'sd3, 1'b0);
    send_word(KIND_PUSH_TAIL, 32'h3000_0003, 8'sd3, 1'b0);
    send_word(KIND_PUSH_HEAD, 32'h3000_0004, 8'sd3, 1'b0);
    send_word(KIND_PUSH_TAIL, 32'h3000_0005, 8'sd3, 1'b0);
    send_word(KIND_PUSH_HEAD, 32'h3000_0006, 8'sd3, 1'b0);
    send_word(KIND_STOP, 32'h8, 8'sd0, 1'b0);
    send_word(KIND_POP, 32'h9, 8'sd0, 1'b0);
    send_word(KIND_START, 32'ha, 8'sd0, 1'b0);
    send_word(KIND_POP, 32'hb, 8'sd0, 1'b0);
    send_word(KIND_UNUSED_HI, 32'hc, 8'sd0, 1'b0);
    send_word(KIND_DRAIN, 32'hd, 8'sd0, 1'b0);
    send_word(KIND_PUSH_TAIL, 32'h5000_0001, 8'sd5, 1'b0);
    send_word(KIND_CLEAR, 32'he, 8'sd0, 1'b0);
    send_word(KIND_POP, 32'hf, 8'sd0, 1'b0);

    settle();
    write_default(4'd15);
    idle_pct = 11;
    repeat (80) random_word();

    settle();
    write_default(4'd0);
    idle_pct = 79;
    repeat (80) random_word();

    settle();
    write_default(4'd9);
    idle_pct = 0;
    repeat (80) random_word();

    settle();
    write_default(4'd7);
    send_word(KIND_START, 32'h10, 8'sd0, 1'b0);
    send_word(KIND_PUSH_TAIL, 32'h7000_0001, 8'sd0, 1'b1);
    send_word(KIND_PUSH_HEAD, 32'h2000_0001, 8'sd2, 1'b0);
    send_word(KIND_CLOSE, 32'h11, 8'sd0, 1'b0);
    send_word(KIND_START, 32'h12, 8'sd0, 1'b0);
    send_word(KIND_POP, 32'h13, 8'sd0, 1'b0);
    send_word(KIND_PEEK, 32'h14, 8'sd0, 1'b0);
    send_word(KIND_PUSH_TAIL, 32'h8000_0001, 8'sd8, 1'b0);
    send_word(KIND_DRAIN, 32'h15, 8'sd0, 1'b0);
    settle();

    $display("Sent %0d words and checked %0d results: %0d full refusals, %0d entries drained.",
             sb.words, sb.results, sb.refusals, sb.drained);
    $display("Default level set to 4, 15, 0, 9 and 7; sender gaps at 0, 11 and 79 percent.");
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    end
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
